// ----- design/clle_pkg.sv -----
// Shared types and codes for the circular linked list engine.
// Holds operation kinds, status codes and the controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package clle_pkg;

    typedef logic [2:0] t_kind;
    typedef logic [1:0] t_status;

    localparam t_kind KIND_INS_FIRST = 3'd0;
    localparam t_kind KIND_INS_LAST  = 3'd1;
    localparam t_kind KIND_DEL_FIRST = 3'd2;
    localparam t_kind KIND_DEL_LAST  = 3'd3;
    localparam t_kind KIND_INS_AT    = 3'd4;
    localparam t_kind KIND_DEL_AT    = 3'd5;
    localparam t_kind KIND_DUMP      = 3'd6;

    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_FULL   = 2'd2;
    localparam t_status ST_BADPOS = 2'd3;

    typedef struct packed {
        logic take;
        logic set_status;
        logic rd_cur;
        logic rd_link;
        logic step;
        logic ins_w1;
        logic ins_w2;
        logic del_w;
        logic dump_ld;
        logic resp_ld;
    } t_cmd;

    typedef struct packed {
        logic is_insert;
        logic is_delete;
        logic is_dump;
        logic code_ok;
        logic count_zero;
        logic steps_zero;
        logic steps_one;
        logic dump_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// ----- design/clle_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the node value and node link stores. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module clle_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/clle_ctrl.sv -----
// Controller state machine for the circular linked list engine.
// Sequences decode, link walks, store writes and result loads; uses clle_pkg.
`timescale 1ns / 1ps
`default_nettype none

module clle_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    output logic                o_ready,
    input  wire clle_pkg::t_stat i_stat,
    output clle_pkg::t_cmd      o_cmd
);
    import clle_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_LINK_RD,
        S_LINK,
        S_INS_W1,
        S_INS_W2,
        S_DEL_W,
        S_DUMP_RD,
        S_DUMP_LD,
        S_RESP
    } t_state;

    t_state r_state, n_state;
    logic   r_ready, n_ready;
    t_cmd   w_cmd;

    always_comb begin
        w_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid && r_ready) begin
                    w_cmd.take = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                w_cmd.set_status = 1'b1;
                if (!i_stat.code_ok || (i_stat.is_dump && i_stat.count_zero) ||
                    (!i_stat.is_insert && !i_stat.is_delete && !i_stat.is_dump)) begin
                    n_state = S_RESP;
                end else if (i_stat.is_dump) begin
                    n_state = S_DUMP_RD;
                end else if (i_stat.is_insert && i_stat.steps_zero) begin
                    n_state = S_INS_W1;
                end else begin
                    n_state = S_LINK_RD;
                end
            end
            S_LINK_RD: begin
                w_cmd.rd_cur = 1'b1;
                n_state      = S_LINK;
            end
            S_LINK: begin
                w_cmd.step = 1'b1;
                if (i_stat.steps_one) begin
                    n_state = i_stat.is_insert ? S_INS_W1 : S_DEL_W;
                end else begin
                    w_cmd.rd_link = 1'b1;
                end
            end
            S_INS_W1: begin
                w_cmd.ins_w1 = 1'b1;
                n_state      = S_INS_W2;
            end
            S_INS_W2: begin
                w_cmd.ins_w2 = 1'b1;
                n_state      = S_RESP;
            end
            S_DEL_W: begin
                w_cmd.del_w = 1'b1;
                n_state     = S_RESP;
            end
            S_DUMP_RD: begin
                w_cmd.rd_cur = 1'b1;
                n_state      = S_DUMP_LD;
            end
            S_DUMP_LD: begin
                if (i_stat.out_free) begin
                    w_cmd.dump_ld = 1'b1;
                    if (i_stat.dump_last) begin
                        n_state = S_IDLE;
                    end else begin
                        w_cmd.rd_link = 1'b1;
                    end
                end
            end
            S_RESP: begin
                if (i_stat.out_free) begin
                    w_cmd.resp_ld = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_ready = (n_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ready <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ready <= n_ready;
        end
    end

    assign o_ready = r_ready;
    assign o_cmd   = w_cmd;

endmodule

`default_nettype wire

// ----- design/clle_datapath.sv -----
// Datapath for the circular linked list engine: pointers, count, free map,
// node stores, free-node finder and result register. Uses clle_pkg, clle_ram.
`timescale 1ns / 1ps
`default_nettype none

module clle_datapath #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire clle_pkg::t_cmd                 i_cmd,
    output clle_pkg::t_stat                     o_stat,
    input  wire clle_pkg::t_kind                i_kind,
    input  wire logic [DATA_WIDTH-1:0]          i_value,
    input  wire logic [$clog2(DEPTH+1)-1:0]     i_position,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic      [DATA_WIDTH-1:0]          o_value_out,
    output logic      [$clog2(DEPTH+1)-1:0]     o_index_out,
    output logic      [$clog2(DEPTH+1)-1:0]     o_count_out,
    output clle_pkg::t_status                   o_status,
    output logic                                o_is_element,
    output logic                                o_last
);
    import clle_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int G  = (DEPTH + 7) / 8;

    t_kind                 r_kind;
    logic [DATA_WIDTH-1:0] r_value;
    logic [CW-1:0]         r_pos;
    logic [CW-1:0]         r_steps;
    logic [CW-1:0]         r_idx;
    logic [AW-1:0]         r_cur;
    logic [AW-1:0]         r_prev;
    logic [AW-1:0]         r_pprev;
    t_status               r_status;
    logic [AW-1:0]         r_head;
    logic [AW-1:0]         r_tail;
    logic [CW-1:0]         r_count;
    logic [DEPTH-1:0]      r_free;
    logic                  r_grp_any [G];
    logic [2:0]            r_grp_idx [G];
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_value;
    logic [CW-1:0]         r_out_index;
    logic [CW-1:0]         r_out_count;
    t_status               r_out_status;
    logic                  r_out_elem;
    logic                  r_out_last;

    logic [G*8-1:0]        w_free_pad;
    logic                  w_grp_any [G];
    logic [2:0]            w_grp_idx [G];
    logic [AW-1:0]         w_new;
    logic [CW-1:0]         w_take_pos;
    logic [CW-1:0]         w_take_steps;
    logic                  w_is_ins;
    logic                  w_is_del;
    logic                  w_is_dump;
    logic                  w_pos_one;
    logic                  w_count_zero;
    logic                  w_out_free;
    t_status               w_code;
    logic [CW:0]           w_pos_x;
    logic [CW:0]           w_cnt_x;
    logic [AW-1:0]         w_nxt_q;
    logic [DATA_WIDTH-1:0] w_val_q;
    logic                  w_re;
    logic [AW-1:0]         w_raddr;
    logic                  w_nxt_we;
    logic [AW-1:0]         w_nxt_waddr;
    logic [AW-1:0]         w_nxt_wdata;

    // free-node finder, stage one: lowest free node within each group of eight
    assign w_free_pad = (G*8)'(r_free);

    always_comb begin
        for (int g = 0; g < G; g++) begin
            w_grp_any[g] = |w_free_pad[g*8 +: 8];
            w_grp_idx[g] = 3'd0;
            for (int j = 7; j >= 0; j--) begin
                if (w_free_pad[g*8 + j]) begin
                    w_grp_idx[g] = 3'(j);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < G; g++) begin
            r_grp_any[g] <= w_grp_any[g];
            r_grp_idx[g] <= w_grp_idx[g];
        end
    end

    always_comb begin
        w_new = '0;
        for (int g = G - 1; g >= 0; g--) begin
            if (r_grp_any[g]) begin
                w_new = AW'(g * 8 + int'(r_grp_idx[g]));
            end
        end
    end

    always_comb begin
        case (i_kind)
            KIND_INS_FIRST, KIND_DEL_FIRST: w_take_pos = CW'(1);
            KIND_INS_LAST:                  w_take_pos = r_count + CW'(1);
            KIND_DEL_LAST:                  w_take_pos = r_count;
            default:                        w_take_pos = i_position;
        endcase
        if (i_kind inside {KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT}) begin
            w_take_steps = w_take_pos - CW'(1);
        end else begin
            w_take_steps = w_take_pos;
        end
    end

    assign w_is_ins     = r_kind inside {KIND_INS_FIRST, KIND_INS_LAST, KIND_INS_AT};
    assign w_is_del     = r_kind inside {KIND_DEL_FIRST, KIND_DEL_LAST, KIND_DEL_AT};
    assign w_is_dump    = (r_kind == KIND_DUMP);
    assign w_pos_one    = (r_pos == CW'(1));
    assign w_count_zero = (r_count == '0);
    assign w_pos_x      = {1'b0, r_pos};
    assign w_cnt_x      = {1'b0, r_count};
    assign w_out_free   = !r_out_valid || i_ready;

    always_comb begin
        w_code = ST_DONE;
        if (w_is_ins) begin
            if (r_count == CW'(DEPTH)) begin
                w_code = ST_FULL;
            end else if (r_pos == '0 || w_pos_x > w_cnt_x + (CW+1)'(1)) begin
                w_code = ST_BADPOS;
            end
        end else if (w_is_del) begin
            if (w_count_zero) begin
                w_code = ST_EMPTY;
            end else if (r_pos == '0 || w_pos_x > w_cnt_x) begin
                w_code = ST_BADPOS;
            end
        end
    end

    assign w_re    = i_cmd.rd_cur || i_cmd.rd_link;
    assign w_raddr = i_cmd.rd_link ? w_nxt_q : r_cur;

    always_comb begin
        w_nxt_we    = i_cmd.ins_w1 || i_cmd.ins_w2 || i_cmd.del_w;
        w_nxt_waddr = w_new;
        w_nxt_wdata = w_new;
        if (i_cmd.ins_w1) begin
            w_nxt_wdata = w_count_zero ? w_new : r_cur;
        end else if (i_cmd.ins_w2) begin
            w_nxt_waddr = r_prev;
        end else if (i_cmd.del_w) begin
            w_nxt_waddr = w_pos_one ? r_tail : r_pprev;
            w_nxt_wdata = r_cur;
        end
    end

    clle_ram #(
        .WIDTH (AW),
        .DEPTH (DEPTH)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_nxt_we),
        .i_waddr (w_nxt_waddr),
        .i_wdata (w_nxt_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_nxt_q)
    );

    clle_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins_w1),
        .i_waddr (w_new),
        .i_wdata (r_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_val_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_free      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ins_w2) begin
                r_free[w_new] <= 1'b0;
                r_count       <= r_count + CW'(1);
                if (w_count_zero) begin
                    r_head <= w_new;
                    r_tail <= w_new;
                end else if (w_pos_one) begin
                    r_head <= w_new;
                end else if (r_prev == r_tail) begin
                    r_tail <= w_new;
                end
            end
            if (i_cmd.del_w) begin
                r_free[r_prev] <= 1'b1;
                r_count        <= r_count - CW'(1);
                if (w_pos_one) begin
                    r_head <= r_cur;
                end else if (r_prev == r_tail) begin
                    r_tail <= r_pprev;
                end
            end
            if (i_cmd.dump_ld || i_cmd.resp_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_kind  <= i_kind;
            r_value <= i_value;
            r_pos   <= w_take_pos;
            r_steps <= w_take_steps;
            r_cur   <= r_head;
            r_prev  <= r_tail;
            r_idx   <= CW'(1);
        end
        if (i_cmd.set_status) begin
            r_status <= w_code;
        end
        if (i_cmd.step) begin
            r_pprev <= r_prev;
            r_prev  <= r_cur;
            r_cur   <= w_nxt_q;
            r_steps <= r_steps - CW'(1);
        end
        if (i_cmd.dump_ld) begin
            r_out_value  <= w_val_q;
            r_out_index  <= r_idx;
            r_out_count  <= r_count;
            r_out_status <= ST_DONE;
            r_out_elem   <= 1'b1;
            r_out_last   <= (r_idx == r_count);
            r_cur        <= w_nxt_q;
            r_idx        <= r_idx + CW'(1);
        end
        if (i_cmd.resp_ld) begin
            r_out_value  <= '0;
            r_out_index  <= '0;
            r_out_count  <= r_count;
            r_out_status <= r_status;
            r_out_elem   <= 1'b0;
            r_out_last   <= 1'b1;
        end
    end

    assign o_stat.is_insert  = w_is_ins;
    assign o_stat.is_delete  = w_is_del;
    assign o_stat.is_dump    = w_is_dump;
    assign o_stat.code_ok    = (w_code == ST_DONE);
    assign o_stat.count_zero = w_count_zero;
    assign o_stat.steps_zero = (r_steps == '0);
    assign o_stat.steps_one  = (r_steps == CW'(1));
    assign o_stat.dump_last  = (r_idx == r_count);
    assign o_stat.out_free   = w_out_free;

    assign o_valid      = r_out_valid;
    assign o_value_out  = r_out_value;
    assign o_index_out  = r_out_index;
    assign o_count_out  = r_out_count;
    assign o_status     = r_out_status;
    assign o_is_element = r_out_elem;
    assign o_last       = r_out_last;

    a_count_matches_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(~r_free) == int'(r_count))
        else $error("element count disagrees with free map");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dump_ld || i_cmd.resp_ld) |-> w_out_free)
        else $error("result register overwritten while occupied");

    a_step_budget: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_steps != '0))
        else $error("link walk stepped past its target");

    a_alloc_is_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_w2 |-> r_free[w_new])
        else $error("allocated node was not free");

    a_last_element_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_elem && r_out_last) |-> (r_out_index == r_out_count))
        else $error("final dumped element index differs from count");

endmodule

`default_nettype wire

// ----- design/circular_linked_list_engine_core.sv -----
// Top level of the circular linked list engine: controller plus datapath.
// Depends on clle_pkg, clle_ctrl, clle_datapath (and clle_ram below it).
//
// Holds an ordered list of up to DEPTH values as a circular singly linked list
// in two node stores (value and link) with a free map; new nodes take the
// lowest free node. One item at a time: o_ready is high only while the engine
// is idle, but an item is taken while the previous result still waits on the
// output register. A status-only item (rejected, kind seven, empty dump) goes
// from decode straight to the result load, an insert at position one skips the
// link walk, other inserts and all deletes walk the links first, and a dump
// holds each element until the output register is free. Walks follow one link
// per cycle through the link store's single read port. No clearing pass is
// needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module circular_linked_list_engine_core #(
    parameter int DEPTH      = 32,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire clle_pkg::t_kind            i_kind,
    input  wire logic [DATA_WIDTH-1:0]      i_value,
    input  wire logic [$clog2(DEPTH+1)-1:0] i_position,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic      [DATA_WIDTH-1:0]      o_value_out,
    output logic      [$clog2(DEPTH+1)-1:0] o_index_out,
    output logic      [$clog2(DEPTH+1)-1:0] o_count_out,
    output clle_pkg::t_status               o_status,
    output logic                            o_is_element,
    output logic                            o_last
);
    import clle_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    clle_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    clle_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_kind       (i_kind),
        .i_value      (i_value),
        .i_position   (i_position),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_value_out  (o_value_out),
        .o_index_out  (o_index_out),
        .o_count_out  (o_count_out),
        .o_status     (o_status),
        .o_is_element (o_is_element),
        .o_last       (o_last)
    );

endmodule

`default_nettype wire
